// ----- src/camproj_pkg.sv -----
// Shared widths, register codes and arithmetic helpers for the camera projection block.
package camproj_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_CAMERA_X        = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y        = 3'd1;
    localparam logic [2:0] CFG_CAMERA_Z        = 3'd2;
    localparam logic [2:0] CFG_CAMERA_ROTATION = 3'd3;
    localparam logic [2:0] CFG_VIEW_WIDTH      = 3'd4;
    localparam logic [2:0] CFG_VIEW_HEIGHT     = 3'd5;
    localparam logic [2:0] CFG_FOV_DEGREES     = 3'd6;

    localparam logic [13:0] VIEW_WIDTH_RST  = 14'd1920;
    localparam logic [13:0] VIEW_HEIGHT_RST = 14'd1080;
    localparam logic [15:0] FOV_RST         = 16'd23040;

    // sine polynomial, Q2.30 coefficients
    localparam logic signed [33:0] SC1  = 34'sd1686629713;
    localparam logic signed [33:0] SC3  = 34'sd693598668;
    localparam logic signed [33:0] SC5  = 34'sd85569306;
    localparam logic signed [33:0] SC7  = 34'sd5026995;
    localparam logic signed [33:0] SC9  = 34'sd172272;
    localparam logic signed [33:0] SC11 = 34'sd3864;
    localparam logic signed [37:0] QONE = 38'sd1073741824;

    // half field of view: n / 45 as (n * ceil(2^27 / 45)) >> 27, exact for n < 2^21
    localparam logic [21:0] HFOV_RECIP = 22'd2982617;

    // per-item widths
    localparam int MAG_W = 43;           // |offset|, quotient
    localparam int DEP_W = 43;           // clamped depth
    localparam int REM_W = 44;           // divider remainder
    localparam int FOCAL_W = 43;
    localparam int DIV_STEPS = 43;
    localparam int DIV_SPS = 2;          // quotient bits per stage
    localparam int DIV_STAGES = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;
    localparam logic [DEP_W-1:0] DEPTH_ONE = 43'd65536;

    // setup divider
    localparam int SDQ_W = 60;
    localparam logic [5:0] SDIV_LAST = 6'd59;
    localparam logic [3:0] AXIS_LAST = 4'd13;
    localparam logic [2:0] HORNER_LAST = 3'd6;
    localparam logic [2:0] SINE_LAST = 3'd7;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] nq;    // dividend bits out at the top, quotient bits in at the bottom
    } div_lane_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic clamped;
    } side_t;

    function automatic logic signed [33:0] sin_coef(logic [2:0] step);
        logic signed [33:0] c;
        case (step)
            3'd1:    c = SC9;
            3'd2:    c = -SC7;
            3'd3:    c = SC5;
            3'd4:    c = -SC3;
            3'd5:    c = SC1;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [32:0] ext33(logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic div_lane_t div_step(div_lane_t l, logic [DEP_W-1:0] d);
        logic [REM_W-1:0] rs;
        logic ge;
        div_lane_t o;
        rs = {l.rem[REM_W-2:0], l.nq[MAG_W-1]};
        ge = rs >= {1'b0, d};
        o.rem = ge ? rs - {1'b0, d} : rs;
        o.nq = {l.nq[MAG_W-2:0], ge};
        return o;
    endfunction

    function automatic div_lane_t div_steps(div_lane_t l, logic [DEP_W-1:0] d, int n);
        div_lane_t o;
        o = l;
        for (int i = 0; i < DIV_SPS; i++)
        begin
            if (i < n)
            begin
                o = div_step(o, d);
            end
        end
        return o;
    endfunction

endpackage

// ----- src/camera_perspective_project_top.sv -----
// Top level: setup sequencer for camera axes and focal length, and the per-point projection pipeline.
//
//  channel   signals                               direction  content
//  -------   -----------------------------------   ---------  ------------------------------
//  s         s_tvalid s_tready s_tdata[95:0]       in         one world point per request
//  m         m_tvalid m_tready m_tdata[63:0]       out        screen position per request
//            m_tuser[1:0]                                     flags
//  cfg       cfg_valid cfg_ready cfg_index cfg_data in         register write
//
// One point enters per cycle while s_tready is high. The pipeline has 3 front stages, 22
// divider stages of two quotient bits each (one in the last) and 3 scale and saturate
// stages; the divider stages set the depth. After reset and after every register write a
// setup pass builds the half field of view by a reciprocal multiply, then the sines, the
// camera axes and the focal length on one shared multiplier and a bit-serial divider;
// s_tready stays low during it. A stalled m side holds the whole pipeline; nothing is lost.
module camera_perspective_project_top
    import camproj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // screen_x, screen_y
    output logic [1:0]  m_tuser,    // depth_clamped, saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_HSET  = 9'b000000010,
        ST_SINE  = 9'b000000100,
        ST_AXIS  = 9'b000001000,
        ST_AXSET = 9'b000010000,
        ST_FMUL  = 9'b000100000,
        ST_FDIV  = 9'b001000000,
        ST_FSET  = 9'b010000000,
        ST_RUN   = 9'b100000000
    } state_t;

    // configuration registers
    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [47:0] rot_reg;
    logic [13:0] vw_reg, vh_reg;
    logic [15:0] fov_reg;

    // setup sequencer
    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [2:0] si_reg;
    logic [2:0] hs_reg;
    logic [3:0] k_reg;
    logic [13:0] h_reg;
    logic [SDQ_W-1:0] dq_reg;
    logic [30:0] rem_reg;
    logic [30:0] dvs_reg;
    logic signed [33:0] t2_reg;
    logic signed [33:0] p_reg;
    logic signed [31:0] sin_reg [8];     // sy cy sp cp sr cr fs fc
    logic signed [31:0] prod_reg [14];
    logic signed [32:0] axis_reg [9];    // depth row, horizontal row, vertical row
    logic [FOCAL_W-1:0] focal_reg;

    logic cfg_hit;
    logic run;
    logic pipe_en;

    assign cfg_ready = 1'b1;
    assign cfg_hit = cfg_valid && (cfg_index <= CFG_FOV_DEGREES);
    assign run = (state_reg == ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            rot_reg <= '0;
            vw_reg <= VIEW_WIDTH_RST;
            vh_reg <= VIEW_HEIGHT_RST;
            fov_reg <= FOV_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CAMERA_X:        cam_x_reg <= cfg_data[31:0];
                CFG_CAMERA_Y:        cam_y_reg <= cfg_data[31:0];
                CFG_CAMERA_Z:        cam_z_reg <= cfg_data[31:0];
                CFG_CAMERA_ROTATION: rot_reg <= cfg_data;
                CFG_VIEW_WIDTH:      vw_reg <= cfg_data[13:0];
                CFG_VIEW_HEIGHT:     vh_reg <= cfg_data[13:0];
                CFG_FOV_DEGREES:     fov_reg <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    // shared setup multiplier: floor(a * b / 2^30)
    logic [15:0] ang_base, ang;
    logic [1:0] quad;
    logic [14:0] arg;
    logic signed [33:0] t_val;
    logic signed [33:0] mq_a, mq_b;
    logic signed [67:0] mq_prod;
    logic signed [37:0] mq_res;
    logic signed [37:0] sine_mag;
    logic signed [31:0] sine_val;

    function automatic logic signed [33:0] sx34(logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    always_comb
    begin
        case (si_reg[2:1])
            2'd0:    ang_base = rot_reg[15:0];
            2'd1:    ang_base = rot_reg[31:16];
            2'd2:    ang_base = rot_reg[47:32];
            default: ang_base = {2'b00, h_reg};
        endcase
        ang = ang_base + (si_reg[0] ? 16'h4000 : 16'h0000);
        quad = ang[15:14];
        arg = quad[0] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
        t_val = {3'b000, arg, 16'h0000};

        mq_a = '0;
        mq_b = '0;
        case (state_reg)
            ST_SINE:
            begin
                if (hs_reg == 3'd0)
                begin
                    mq_a = t_val;
                    mq_b = t_val;
                end
                else if (hs_reg == HORNER_LAST)
                begin
                    mq_a = p_reg;
                    mq_b = t_val;
                end
                else
                begin
                    mq_a = (hs_reg == 3'd1) ? -SC11 : p_reg;
                    mq_b = t2_reg;
                end
            end
            ST_AXIS:
            begin
                case (k_reg)
                    4'd0:    begin mq_a = sx34(sin_reg[4]);  mq_b = sx34(sin_reg[2]); end
                    4'd1:    begin mq_a = sx34(sin_reg[5]);  mq_b = sx34(sin_reg[2]); end
                    4'd2:    begin mq_a = sx34(sin_reg[3]);  mq_b = sx34(sin_reg[1]); end
                    4'd3:    begin mq_a = sx34(sin_reg[3]);  mq_b = sx34(sin_reg[0]); end
                    4'd4:    begin mq_a = sx34(prod_reg[0]); mq_b = sx34(sin_reg[1]); end
                    4'd5:    begin mq_a = sx34(sin_reg[5]);  mq_b = sx34(sin_reg[0]); end
                    4'd6:    begin mq_a = sx34(prod_reg[0]); mq_b = sx34(sin_reg[0]); end
                    4'd7:    begin mq_a = sx34(sin_reg[5]);  mq_b = sx34(sin_reg[1]); end
                    4'd8:    begin mq_a = sx34(sin_reg[4]);  mq_b = sx34(sin_reg[3]); end
                    4'd9:    begin mq_a = sx34(prod_reg[1]); mq_b = sx34(sin_reg[1]); end
                    4'd10:   begin mq_a = sx34(sin_reg[4]);  mq_b = sx34(sin_reg[0]); end
                    4'd11:   begin mq_a = sx34(prod_reg[1]); mq_b = sx34(sin_reg[0]); end
                    4'd12:   begin mq_a = sx34(sin_reg[4]);  mq_b = sx34(sin_reg[1]); end
                    4'd13:   begin mq_a = sx34(sin_reg[5]);  mq_b = sx34(sin_reg[3]); end
                    default: ;
                endcase
            end
            default: ;
        endcase
        mq_prod = mq_a * mq_b;
        mq_res = mq_prod[67:30];

        // quarter wave clamped to [0, 1.0], sign from the upper half turn
        if (mq_res < 0)
            sine_mag = '0;
        else if (mq_res > QONE)
            sine_mag = QONE;
        else
            sine_mag = mq_res;
        sine_val = quad[1] ? -sine_mag[31:0] : sine_mag[31:0];
    end

    // bit-serial restoring divider for the focal length, reciprocal for the half fov
    logic [31:0] sd_rs;
    logic sd_ge;
    logic [30:0] rem_next;
    logic [SDQ_W-1:0] dq_next;
    logic [20:0] hnum;
    logic [42:0] hmul;
    logic [14:0] hq;
    logic signed [31:0] fs_c, fc_c;
    logic [44:0] fnum;

    always_comb
    begin
        sd_rs = {rem_reg, dq_reg[SDQ_W-1]};
        sd_ge = sd_rs >= {1'b0, dvs_reg};
        rem_next = sd_ge ? 31'(sd_rs - {1'b0, dvs_reg}) : sd_rs[30:0];
        dq_next = {dq_reg[SDQ_W-2:0], sd_ge};
        hnum = {1'b0, fov_reg, 4'b0000} + 21'd22;
        hmul = hnum * HFOV_RECIP;
        hq = hmul[41:27];
        fs_c = (sin_reg[6] < 32'sd1) ? 32'sd1 : sin_reg[6];
        fc_c = (sin_reg[7] < 32'sd0) ? 32'sd0 : sin_reg[7];
        fnum = vw_reg * fc_c[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            si_reg <= '0;
            hs_reg <= '0;
            k_reg <= '0;
        end
        else if (cfg_hit)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    cnt_reg <= '0;
                    state_reg <= ST_HSET;
                end
                ST_FDIV:
                begin
                    if (cnt_reg == SDIV_LAST)
                        state_reg <= ST_FSET;
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_HSET:
                begin
                    si_reg <= '0;
                    hs_reg <= '0;
                    state_reg <= ST_SINE;
                end
                ST_SINE:
                begin
                    if (hs_reg == HORNER_LAST)
                    begin
                        hs_reg <= '0;
                        if (si_reg == SINE_LAST)
                        begin
                            k_reg <= '0;
                            state_reg <= ST_AXIS;
                        end
                        else
                            si_reg <= si_reg + 3'd1;
                    end
                    else
                        hs_reg <= hs_reg + 3'd1;
                end
                ST_AXIS:
                begin
                    if (k_reg == AXIS_LAST)
                        state_reg <= ST_AXSET;
                    else
                        k_reg <= k_reg + 4'd1;
                end
                ST_AXSET:
                    state_reg <= ST_FMUL;
                ST_FMUL:
                begin
                    cnt_reg <= '0;
                    state_reg <= ST_FDIV;
                end
                ST_FSET:
                    state_reg <= ST_RUN;
                ST_RUN:
                    state_reg <= ST_RUN;
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    // setup datapath, no reset: every value is written before it is read
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_FDIV:
            begin
                dq_reg <= dq_next;
                rem_reg <= rem_next;
            end
            ST_HSET:
            begin
                // half field of view kept inside the first quarter turn
                if (hq == 15'd0)
                    h_reg <= 14'd1;
                else if (hq > 15'd16383)
                    h_reg <= 14'd16383;
                else
                    h_reg <= hq[13:0];
            end
            ST_SINE:
            begin
                if (hs_reg == 3'd0)
                    t2_reg <= mq_res[33:0];
                else if (hs_reg == HORNER_LAST)
                    sin_reg[si_reg] <= sine_val;
                else
                    p_reg <= sin_coef(hs_reg) + mq_res[33:0];
            end
            ST_AXIS:
                prod_reg[k_reg] <= mq_res[31:0];
            ST_AXSET:
            begin
                axis_reg[0] <= ext33(prod_reg[2]);
                axis_reg[1] <= ext33(prod_reg[3]);
                axis_reg[2] <= ext33(sin_reg[2]);
                axis_reg[3] <= ext33(prod_reg[4]) - ext33(prod_reg[5]);
                axis_reg[4] <= ext33(prod_reg[6]) + ext33(prod_reg[7]);
                axis_reg[5] <= -ext33(prod_reg[8]);
                axis_reg[6] <= -(ext33(prod_reg[9]) + ext33(prod_reg[10]));
                axis_reg[7] <= ext33(prod_reg[12]) - ext33(prod_reg[11]);
                axis_reg[8] <= ext33(prod_reg[13]);
            end
            ST_FMUL:
            begin
                dq_reg <= {fnum, 15'h0000};
                dvs_reg <= fs_c[30:0];
                rem_reg <= '0;
            end
            ST_FSET:
                focal_reg <= dq_reg[FOCAL_W-1:0];
            default: ;
        endcase
    end

    // ---------------- projection pipeline ----------------
    logic out_valid_reg;
    assign pipe_en = !out_valid_reg || m_tready;
    assign s_tready = pipe_en && run;

    // S1: offset from the camera
    logic v1_reg;
    logic signed [32:0] d_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (pipe_en)
            v1_reg <= s_tvalid && run;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            d_reg[0] <= {s_tdata[31], s_tdata[31:0]} - {cam_x_reg[31], cam_x_reg};
            d_reg[1] <= {s_tdata[63], s_tdata[63:32]} - {cam_y_reg[31], cam_y_reg};
            d_reg[2] <= {s_tdata[95], s_tdata[95:64]} - {cam_z_reg[31], cam_z_reg};
        end
    end

    // S2: nine Q30 products, floored to Q16
    logic v2_reg;
    logic signed [43:0] term_reg [9];
    logic signed [65:0] dprod [9];

    always_comb
    begin
        for (int j = 0; j < 9; j++)
        begin
            dprod[j] = d_reg[j % 3] * axis_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (pipe_en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int j = 0; j < 9; j++)
            begin
                term_reg[j] <= dprod[j][65:22];
            end
        end
    end

    // S3 and divider: |offset| * 2^16 / depth, two quotient bits per stage, one in the last
    logic [DIV_STAGES:0] dv_valid_reg;
    div_lane_t lx_reg [DIV_STAGES+1];
    div_lane_t ly_reg [DIV_STAGES+1];
    logic [DEP_W-1:0] dep_reg [DIV_STAGES+1];
    side_t side_reg [DIV_STAGES+1];

    logic signed [43:0] sum_z, sum_h, sum_v;
    logic [43:0] abs_h, abs_v;
    logic clamp_z;

    always_comb
    begin
        sum_z = term_reg[0] + term_reg[1] + term_reg[2];
        sum_h = term_reg[3] + term_reg[4] + term_reg[5];
        sum_v = term_reg[6] + term_reg[7] + term_reg[8];
        clamp_z = sum_z < 44'sd65536;
        abs_h = sum_h[43] ? -sum_h : sum_h;
        abs_v = sum_v[43] ? -sum_v : sum_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg <= '0;
        else if (pipe_en)
            dv_valid_reg <= {dv_valid_reg[DIV_STAGES-1:0], v2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dep_reg[0] <= clamp_z ? DEPTH_ONE : sum_z[DEP_W-1:0];
            side_reg[0] <= '{neg_x: sum_h[43], neg_y: sum_v[43], clamped: clamp_z};
            lx_reg[0].rem <= {{(REM_W-16){1'b0}}, abs_h[MAG_W-1 -: 16]};
            lx_reg[0].nq <= {abs_h[MAG_W-17:0], 16'h0000};
            ly_reg[0].rem <= {{(REM_W-16){1'b0}}, abs_v[MAG_W-1 -: 16]};
            ly_reg[0].nq <= {abs_v[MAG_W-17:0], 16'h0000};
        end
    end

    for (genvar gs = 1; gs <= DIV_STAGES; gs++)
    begin : g_div
        localparam int LEFT = DIV_STEPS - (gs - 1) * DIV_SPS;
        localparam int NSTEP = (LEFT >= DIV_SPS) ? DIV_SPS : LEFT;
        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                lx_reg[gs] <= div_steps(lx_reg[gs-1], dep_reg[gs-1], NSTEP);
                ly_reg[gs] <= div_steps(ly_reg[gs-1], dep_reg[gs-1], NSTEP);
                dep_reg[gs] <= dep_reg[gs-1];
                side_reg[gs] <= side_reg[gs-1];
            end
        end
    end

    // M1: ratio * focal as four partial products of about 22 by 22 bits
    logic vm1_reg, vm2_reg;
    side_t sm1_reg, sm2_reg;
    logic [41:0] hhx_reg, hhy_reg;     // high * high
    logic [43:0] mdx_reg, mdy_reg;     // both cross products
    logic [43:0] llx_reg, lly_reg;     // low * low
    logic [MAG_W-1:0] rx, ry;

    assign rx = lx_reg[DIV_STAGES].nq;
    assign ry = ly_reg[DIV_STAGES].nq;

    // M2: recombine, range check, back to Q8
    logic [86:0] px, py;
    logic ovx_reg, ovy_reg;
    logic [32:0] tx_reg, ty_reg;

    assign px = {1'b0, hhx_reg, 44'h0} + {21'h0, mdx_reg, 22'h0} + {43'h0, llx_reg};
    assign py = {1'b0, hhy_reg, 44'h0} + {21'h0, mdy_reg, 22'h0} + {43'h0, lly_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            vm1_reg <= dv_valid_reg[DIV_STAGES];
            vm2_reg <= vm1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            hhx_reg <= rx[42:22] * focal_reg[42:22];
            mdx_reg <= rx[42:22] * focal_reg[21:0] + rx[21:0] * focal_reg[42:22];
            llx_reg <= rx[21:0] * focal_reg[21:0];
            hhy_reg <= ry[42:22] * focal_reg[42:22];
            mdy_reg <= ry[42:22] * focal_reg[21:0] + ry[21:0] * focal_reg[42:22];
            lly_reg <= ry[21:0] * focal_reg[21:0];
            sm1_reg <= side_reg[DIV_STAGES];
            ovx_reg <= px > (87'd1 << 56);
            ovy_reg <= py > (87'd1 << 56);
            tx_reg <= px[56:24];
            ty_reg <= py[56:24];
            sm2_reg <= sm1_reg;
        end
    end

    // M3: center, saturate, output register
    logic [40:0] termx, termy;
    logic signed [42:0] scx, scy;
    logic signed [31:0] sx_sat, sy_sat;
    logic sat_x, sat_y;
    logic signed [31:0] sx_reg, sy_reg;
    logic clamped_reg, sat_reg;

    always_comb
    begin
        termx = ovx_reg ? (41'd1 << 40) : {8'h00, tx_reg};
        termy = ovy_reg ? (41'd1 << 40) : {8'h00, ty_reg};
        scx = {22'h0, vw_reg, 7'h00} + (sm2_reg.neg_x ? -{2'b00, termx} : {2'b00, termx});
        scy = {22'h0, vh_reg, 7'h00} + (sm2_reg.neg_y ? {2'b00, termy} : -{2'b00, termy});
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (scx > 43'sd2147483647)
            sx_sat = 32'sh7FFFFFFF;
        else if (scx < -43'sd2147483648)
            sx_sat = 32'sh80000000;
        else
        begin
            sx_sat = scx[31:0];
            sat_x = 1'b0;
        end
        if (scy > 43'sd2147483647)
            sy_sat = 32'sh7FFFFFFF;
        else if (scy < -43'sd2147483648)
            sy_sat = 32'sh80000000;
        else
        begin
            sy_sat = scy[31:0];
            sat_y = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= vm2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sx_reg <= sx_sat;
            sy_reg <= sy_sat;
            clamped_reg <= sm2_reg.clamped;
            sat_reg <= sat_x || sat_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {sy_reg, sx_reg};
    assign m_tuser = {sat_reg, clamped_reg};

    // ---------------- checks ----------------
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[DIV_STAGES] |->
            (lx_reg[DIV_STAGES].rem < {1'b0, dep_reg[DIV_STAGES]}) &&
            (ly_reg[DIV_STAGES].rem < {1'b0, dep_reg[DIV_STAGES]}))
        else $error("divider remainder not below depth");

    a_depth_floor: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[0] && side_reg[0].clamped |-> dep_reg[0] == DEPTH_ONE)
        else $error("clamped depth is not one");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index <= CFG_FOV_DEGREES) |=> state_reg == ST_LOAD)
        else $error("register write did not restart setup");

endmodule

// ----- dv/tb_camera_perspective_project_top.sv -----
// Testbench for the camera projection block: directed and random points checked against a local projection model.
`timescale 1ns / 1ps

module tb_camera_perspective_project_top;
    import camproj_pkg::*;

    localparam logic [2:0] CFG_NONE = 3'd7;   // index past the register list, ignored
    localparam int PIPE_LAT = 40;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;      // point_x, point_y, point_z
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;      // screen_x, screen_y
    logic [1:0]  m_tuser;      // depth_clamped, saturated
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               clamped;
        logic               sat;
    } screen_t;

    // local copy of the camera registers
    logic signed [31:0] cam_x, cam_y, cam_z;
    logic [47:0]        cam_rot;
    logic [13:0]        vw, vh;
    logic [15:0]        fov;

    screen_t screen_q[$];
    int      mismatches;
    int      points_sent;
    int      results_seen;
    int      writes_done;
    bit      idle_on;      // random idling enabled on both sides
    int      sink_hold;    // cycles the receiver still holds off

    camera_perspective_project_top uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- projection model ----------------
    function automatic longint mulq(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint quarter_sin(longint x);
        longint t, t2, p;
        t = x <<< 16;
        t2 = (t * t) >>> 30;
        p = -3864;
        p = 172272 + mulq(p, t2);
        p = -5026995 + mulq(p, t2);
        p = 85569306 + mulq(p, t2);
        p = -693598668 + mulq(p, t2);
        p = 1686629713 + mulq(p, t2);
        p = mulq(p, t);
        if (p < 0) p = 0;
        if (p > 64'd1073741824) p = 1073741824;
        return p;
    endfunction

    function automatic longint sin16(logic [15:0] a);
        longint v;
        longint x;
        x = a[13:0];
        v = a[14] ? quarter_sin(16384 - x) : quarter_sin(x);
        return a[15] ? -v : v;
    endfunction

    function automatic longint cos16(logic [15:0] a);
        return sin16(a + 16'd16384);
    endfunction

    function automatic longint scaled(longint off, longint depth, longint unsigned focal);
        bit neg;
        longint unsigned mag, r, t;
        neg = off < 0;
        mag = neg ? -off : off;
        r = (mag << 16) / depth;
        if (r != 0 && focal > (64'd1 << 56) / r)
            t = 64'd1 << 40;
        else
            t = (r * focal) >> 24;
        return neg ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint clip32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin sat = 1; return 2147483647; end
        if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic screen_t project(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz);
        longint sy_, cy_, sp_, cp_, sr_, cr_, srsp, crsp;
        longint d0, d1, d2, hx, vy, dz, hf, fs, fc;
        longint unsigned focal;
        bit sat;
        screen_t r;
        sat = 0;
        sy_ = sin16(cam_rot[15:0]);  cy_ = cos16(cam_rot[15:0]);
        sp_ = sin16(cam_rot[31:16]); cp_ = cos16(cam_rot[31:16]);
        sr_ = sin16(cam_rot[47:32]); cr_ = cos16(cam_rot[47:32]);
        srsp = mulq(sr_, sp_);
        crsp = mulq(cr_, sp_);
        d0 = longint'(px) - longint'(cam_x);
        d1 = longint'(py) - longint'(cam_y);
        d2 = longint'(pz) - longint'(cam_z);
        dz = ((d0 * mulq(cp_, cy_)) >>> 22) + ((d1 * mulq(cp_, sy_)) >>> 22)
           + ((d2 * sp_) >>> 22);
        hx = ((d0 * (mulq(srsp, cy_) - mulq(cr_, sy_))) >>> 22)
           + ((d1 * (mulq(srsp, sy_) + mulq(cr_, cy_))) >>> 22)
           + ((d2 * -mulq(sr_, cp_)) >>> 22);
        vy = ((d0 * -(mulq(crsp, cy_) + mulq(sr_, sy_))) >>> 22)
           + ((d1 * -(mulq(crsp, sy_) - mulq(sr_, cy_))) >>> 22)
           + ((d2 * mulq(cr_, cp_)) >>> 22);
        r.clamped = dz < 65536;
        if (r.clamped) dz = 65536;
        hf = (longint'(fov) * 16 + 22) / 45;
        if (hf < 1) hf = 1;
        if (hf > 16383) hf = 16383;
        fs = sin16(hf[15:0]);
        fc = cos16(hf[15:0]);
        if (fs < 1) fs = 1;
        if (fc < 0) fc = 0;
        focal = ((longint'(vw) * fc) << 15) / fs;
        r.sx = clip32(longint'(vw) * 128 + scaled(hx, dz, focal), sat);
        r.sy = clip32(longint'(vh) * 128 - scaled(vy, dz, focal), sat);
        r.sat = sat;
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("ERROR at %0t result %0d: %s got %0d want %0d",
                 $realtime, results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        screen_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (screen_q.size() == 0)
                report_mismatch("unexpected result, sx", $signed(m_tdata[31:0]), 0);
            else
            begin
                want = screen_q.pop_front();
                if ($signed(m_tdata[31:0]) != want.sx)
                    report_mismatch("screen_x", $signed(m_tdata[31:0]), want.sx);
                if ($signed(m_tdata[63:32]) != want.sy)
                    report_mismatch("screen_y", $signed(m_tdata[63:32]), want.sy);
                if (m_tuser[0] != want.clamped)
                    report_mismatch("depth_clamped", m_tuser[0], want.clamped);
                if (m_tuser[1] != want.sat)
                    report_mismatch("saturated", m_tuser[1], want.sat);
            end
            results_seen++;
        end
    end

    // receiver: random ready, or a counted hold-off when asked
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(idle_on && $urandom_range(99) < 34);
    end

    // ---------------- stimulus ----------------
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        do @(posedge clk); while (!s_tready);
        screen_q.push_back(project(px, py, pz));
        points_sent++;
        if (idle_on && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering, then wait until every request has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (screen_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        writes_done++;
        case (idx)
            CFG_CAMERA_X:        cam_x = val[31:0];
            CFG_CAMERA_Y:        cam_y = val[31:0];
            CFG_CAMERA_Z:        cam_z = val[31:0];
            CFG_CAMERA_ROTATION: cam_rot = val;
            CFG_VIEW_WIDTH:      vw = val[13:0];
            CFG_VIEW_HEIGHT:     vh = val[13:0];
            CFG_FOV_DEGREES:     fov = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [47:0] rot, logic [13:0] w, logic [13:0] h,
                                logic [15:0] f);
        drain();
        write_reg(CFG_CAMERA_X, {16'h0, x});
        write_reg(CFG_CAMERA_Y, {16'h0, y});
        write_reg(CFG_CAMERA_Z, {16'h0, z});
        write_reg(CFG_CAMERA_ROTATION, rot);
        write_reg(CFG_VIEW_WIDTH, {34'h0, w});
        write_reg(CFG_VIEW_HEIGHT, {34'h0, h});
        write_reg(CFG_FOV_DEGREES, {32'h0, f});
    endtask

    // a point near the camera so most results land on screen
    task automatic send_near(int spread);
        send_point(cam_x + $urandom_range(0, 2 * spread) - spread,
                   cam_y + $urandom_range(0, 2 * spread) - spread,
                   cam_z + $urandom_range(0, 2 * spread) - spread);
    endtask

    task automatic test_directed();
        // reset registers: camera at origin looking down +x, 90 degree fov
        send_point(32'd2560, 32'd0, 32'd0);
        send_point(32'd2560, 32'd256, -32'sd256);
        send_point(32'd0, 32'd0, 32'd0);                 // depth zero, clamped
        send_point(-32'sd25600, 32'd500, 32'd500);       // behind the camera
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'd256, 32'h7FFFFFFF, 32'h80000000); // huge offset, saturates
        send_point(32'h7FFFFFFF, 32'd1, 32'hFFFFFFFF);
        // camera at the extremes, full rotation bits, smallest view, one degree fov
        write_camera(32'h7FFFFFFF, 32'h80000000, 32'd0, 48'hFFFF_FFFF_FFFF,
                     14'd1, 14'd1, 16'd256);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'd0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'd0);
        send_point(32'd0, 32'd0, 32'h80000000);
        // zero size view, fov field outside the useful range
        write_camera(32'd0, 32'd0, 32'd0, 48'h4000_C000_8000, 14'd0, 14'd0, 16'd0);
        send_point(32'd1000, 32'd2000, 32'd3000);
        send_point(-32'sd1000, 32'd2000, -32'sd3000);
        write_camera(32'd0, 32'd0, 32'd0, 48'h0000_4000_4000, 14'h3FFF, 14'h3FFF,
                     16'hFFFF);
        send_point(32'd1000, 32'd2000, 32'd3000);
        send_point(32'd1000, -32'sd2000, -32'sd3000);
        write_camera(32'd0, 32'd0, 32'd0, 48'h0, 14'd8192, 14'd8192, 16'd45824);
        send_point(32'd2560, 32'd100, 32'd100);
        send_point(32'd2560, 32'h7FFFFFF, 32'd0);
        drain();
        write_reg(CFG_NONE, 48'hFFFF_FFFF_FFFF);         // ignored write
        send_point(32'd2560, 32'd100, 32'd100);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                write_camera($urandom, $urandom, $urandom,
                             {16'($urandom_range(65535)), $urandom},
                             (n % 120 == 0) ? 14'($urandom_range(16383))
                                            : 14'($urandom_range(1, 2000)),
                             14'($urandom_range(16383)),
                             (n % 180 == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(2560, 40000)));
            if (n == 150) idle_on = 0;     // a run with no idling
            if (n == 230) idle_on = 1;
            case ($urandom_range(9))
                0:       send_point($urandom, $urandom, $urandom);
                1:       send_near(1 << $urandom_range(0, 30));
                default: send_near(1 << $urandom_range(8, 20));
            endcase
        end
    endtask

    task automatic test_backpressure();
        drain();
        sink_hold = 300;    // receiver stalls while points keep coming
        for (int n = 0; n < 60; n++)
            send_near(1 << 14);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CAMERA_X;
        cfg_data <= '0;
        cam_x = 0; cam_y = 0; cam_z = 0; cam_rot = '0;
        vw = VIEW_WIDTH_RST; vh = VIEW_HEIGHT_RST; fov = FOV_RST;
        mismatches = 0; points_sent = 0; results_seen = 0; writes_done = 0;
        idle_on = 1;
        sink_hold = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(380);
        test_backpressure();

        drain();
        repeat (PIPE_LAT) @(posedge clk);
        $display("Covered %0d points and %0d register writes, extremes of view and fov,",
                 points_sent, writes_done);
        $display("depth clamp, saturation, random idling and a long output stall.");
        if (mismatches == 0 && screen_q.size() == 0)
            $display("camera_perspective_project_top: match");
        else
            $display("camera_perspective_project_top: mismatch");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Timeout with %0d results outstanding", screen_q.size());
        $display("camera_perspective_project_top: mismatch");
        $finish;
    end

endmodule
